/* design/assert_macros.svh */
// Assertion helpers for the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

/* design/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    // Request actions.
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_SERVE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // Operations broadcast to every cell of the row.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   entry_id;
        logic [PRIO_W-1:0] entry_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              served_valid;
        logic [ID_W-1:0]   served_id;
        logic [PRIO_W-1:0] served_priority;
        logic [OCC_W-1:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     entry;
    } cell_cmd_t;

    // Travels from a cell to its right-hand neighbor.
    typedef struct packed {
        entry_t entry;
        logic   ge;
        logic   seen;
    } cell_link_t;

endpackage

`default_nettype wire

/* design/stable_priority_queue_core.sv */
// Bounded priority queue of DEPTH entries kept in descending priority order, with
// entries of equal priority in arrival order, built as a row of identical cells
// that each hold one entry and trade entries with their neighbors. For add, remove
// and serve requests every cell compares its entry with the request at once and
// the cells beyond the slot shift right to open it or left to close one. An
// update request is a removal pass through the row followed by an insertion pass,
// and the request channel stalls during the second. Every request yields one
// result, registered behind a one-entry skid stage, so a request is still taken
// while one finished result waits; the channel stalls while the skid stage is
// occupied. Entries above the occupancy hold stale data and are never reported.
`default_nettype none
`include "assert_macros.svh"

module stable_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire spq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output spq_pkg::rsp_t      rsp
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                busy_reg;
    logic                busy_next;
    spq_pkg::entry_t     pend_reg;
    spq_pkg::entry_t     pend_next;

    logic                accept;
    logic                full;
    logic                found;
    logic                skid_full;
    logic                res_valid;
    spq_pkg::rsp_t       res;
    spq_pkg::cell_cmd_t  cmd;
    logic [DEPTH-1:0]    live;
    spq_pkg::cell_link_t lnk [DEPTH+1];
    logic [COUNT_W+spq_pkg::OCC_W-1:0] occ_wide;

    // The insertion pass of an update or a parked result holds the request channel.
    assign req_stall = busy_reg || skid_full;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == DEPTH_C);
    assign found     = lnk[DEPTH].seen;

    // Pick the operation that the row performs this cycle.
    always_comb
    begin
        cmd = '{op: spq_pkg::CELL_HOLD,
                entry: '{id: req.entry_id, prio: req.entry_priority}};
        if (busy_reg)
        begin
            cmd.entry = pend_reg;
            cmd.op    = full ? spq_pkg::CELL_HOLD : spq_pkg::CELL_INSERT;
        end
        else if (accept)
        begin
            unique case (req.action)
                spq_pkg::ACT_ADD:
                begin
                    cmd.op = full ? spq_pkg::CELL_HOLD : spq_pkg::CELL_INSERT;
                end
                spq_pkg::ACT_REMOVE, spq_pkg::ACT_UPDATE:
                begin
                    cmd.op = spq_pkg::CELL_DELETE;
                end
                spq_pkg::ACT_SERVE:
                begin
                    cmd.op = (count_reg == '0) ? spq_pkg::CELL_HOLD : spq_pkg::CELL_POP;
                end
                default:
                begin
                    cmd.op = spq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // Result, occupancy and update sequencing.
    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        pend_next  = pend_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (busy_reg)
        begin
            // Insertion half of an update; the removal already happened.
            busy_next = 1'b0;
            res_valid = 1'b1;
            if (full)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (accept)
        begin
            unique case (req.action)
                spq_pkg::ACT_ADD:
                begin
                    res_valid = 1'b1;
                    if (full)
                    begin
                        res.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::ACT_REMOVE:
                begin
                    res_valid = 1'b1;
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        res.status = spq_pkg::ST_ABSENT;
                    end
                end
                spq_pkg::ACT_UPDATE:
                begin
                    // An absent id still gets added by the insertion pass.
                    busy_next = 1'b1;
                    pend_next = cmd.entry;
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                spq_pkg::ACT_SERVE:
                begin
                    res_valid = 1'b1;
                    if (count_reg == '0)
                    begin
                        res.status = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res.served_valid    = 1'b1;
                        res.served_id       = lnk[1].entry.id;
                        res.served_priority = lnk[1].entry.prio;
                        count_next          = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
        occ_wide      = {{spq_pkg::OCC_W{1'b0}}, count_next};
        res.occupancy = occ_wide[spq_pkg::OCC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // The left end of the row sees an always-true ge so that slot zero takes
    // a new entry that outranks the head.
    assign lnk[0] = '{entry: cmd.entry, ge: 1'b1, seen: 1'b0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t right_entry;

        assign live[i] = (COUNT_W'(i) < count_reg);

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cmd.entry;
        end
        else
        begin : g_mid
            assign right_entry = lnk[i+2].entry;
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .live        (live[i]),
            .left        (lnk[i]),
            .right_entry (right_entry),
            .link        (lnk[i+1])
        );
    end

    spq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .skid_full (skid_full)
    );

    // An accepted update always runs its insertion pass in the next cycle.
    `ASSERT_NEXT(a_update_second_pass, clk, rst_n,
                 accept && (req.action == spq_pkg::ACT_UPDATE), busy_reg)
    // The insertion pass clears busy_reg in the cycle after it starts.
    `ASSERT_NEXT(a_update_one_cycle, clk, rst_n, busy_reg, !busy_reg)
    // Serving a non-empty queue takes exactly one entry out.
    `ASSERT_NEXT(a_serve_pops_one, clk, rst_n,
                 accept && (req.action == spq_pkg::ACT_SERVE) && (count_reg != '0),
                 (count_reg + 1'b1) == $past(count_reg))
    // The two front entries stay in descending priority order.
    `ASSERT_SAME(a_head_ordered, clk, rst_n, live[1],
                 lnk[1].entry.prio >= lnk[2].entry.prio)

endmodule

`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_cmd_t cmd,
    input  wire logic               live,
    input  wire spq_pkg::cell_link_t left,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::cell_link_t     link
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            ge;
    logic            seen;

    // Held entries form a descending run, so ge is true over a prefix of the row.
    assign ge   = live && (entry_reg.prio >= cmd.entry.prio);
    assign seen = left.seen ||
                  ((cmd.op == spq_pkg::CELL_DELETE) && live && (entry_reg.id == cmd.entry.id));

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            spq_pkg::CELL_INSERT:
            begin
                if (!ge)
                begin
                    entry_next = left.ge ? cmd.entry : left.entry;
                end
            end
            spq_pkg::CELL_DELETE:
            begin
                if (seen)
                begin
                    entry_next = right_entry;
                end
            end
            spq_pkg::CELL_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link = '{entry: entry_reg, ge: ge, seen: seen};

endmodule

`default_nettype wire

/* design/spq_out_buf.sv */
`default_nettype none

module spq_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    input  wire spq_pkg::rsp_t res,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output spq_pkg::rsp_t      rsp,
    output logic               skid_full
);

    logic          valid_reg;
    logic          valid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    spq_pkg::rsp_t data_reg;
    spq_pkg::rsp_t data_next;
    spq_pkg::rsp_t skid_reg;
    spq_pkg::rsp_t skid_next;

    always_comb
    begin
        valid_next      = valid_reg;
        skid_valid_next = skid_valid_reg;
        data_next       = data_reg;
        skid_next       = skid_reg;
        if (!valid_reg || !rsp_stall)
        begin
            // The output slot is free or drains now: refill it, skid first.
            if (skid_valid_reg)
            begin
                data_next       = skid_reg;
                valid_next      = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                data_next  = res;
                valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;
    assign skid_full = skid_valid_reg;

endmodule

`default_nettype wire
